/* rtl/fpha_pkg.sv */
// Shared types and codes for the fit policy hole allocator.
package fpha_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Placement policy codes; the unused code behaves as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 2'd1;

    // Field widths
    localparam int HOLE_IDX_W = 4;
    localparam int REQ_W      = 16;
    localparam int COUNT_W    = 5;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Control from the sequencer to the fit compare unit
    typedef struct packed {
        logic       clr;    // start a new search
        logic       chk;    // a hole size is ready to examine
        logic [1:0] policy;
    } t_fit_ctl;

endpackage

/* rtl/fpha_fit_unit.sv */
// Shared fit compare unit: examines one hole per cycle while chk is set and keeps the running pick.
module fpha_fit_unit #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpha_pkg::t_fit_ctl    i_ctl,
    input  logic [SIZE_BITS-1:0]  i_req,
    input  logic [SIZE_BITS-1:0]  i_hole_size,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic                  i_used,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_pick
);
    import fpha_pkg::*;

    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_left;
    logic                 n_found;
    logic [IDX_W-1:0]     n_pick;
    logic [SIZE_BITS-1:0] n_left;
    logic                 fits;
    logic                 take;
    logic [SIZE_BITS-1:0] left;

    // Compare the hole against the request and the best so far
    always_comb begin
        fits = i_ctl.chk && !i_used && (i_hole_size >= i_req);
        left = i_hole_size - i_req;
        take = fits && (!r_found
                        || (i_ctl.policy == POL_BEST  && left < r_left)
                        || (i_ctl.policy == POL_WORST && left > r_left));
        if (i_ctl.clr) begin
            n_found = 1'b0;
            n_pick  = '0;
            n_left  = '0;
        end else begin
            n_found = r_found || fits;
            n_pick  = take ? i_idx : r_pick;
            n_left  = take ? left  : r_left;
        end
    end

    // Hold the running pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
        r_pick <= n_pick;
        r_left <= n_left;
    end

    // Expose the pick including the hole examined this cycle
    assign o_found = n_found;
    assign o_pick  = n_pick;

`ifndef SYNTHESIS
    a_clr_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |=> !r_found)
        else $error("search did not restart on clear");
    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found && !i_ctl.clr |-> o_found)
        else $error("found flag dropped during a search");
    a_first_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found && !i_ctl.clr && i_ctl.policy != POL_BEST && i_ctl.policy != POL_WORST
        |-> o_pick == r_pick)
        else $error("first fit pick changed after a hit");
`endif

endmodule

/* rtl/fit_policy_hole_allocator.sv */
// Hole allocator: first, best or worst fit over a table of hole sizes.
// Load and clear beats give no result; busy stays low.
// An allocate beat scans L = min(hole_count, MAX_HOLES) holes, one per cycle through
// the size memory read port and one compare unit. Busy is high while scanning; the
// result strobe o_valid is high in the cycle after the last busy one, for one cycle only.
// Reset clears policy, hole count and all used marks; hole sizes are unknown until loaded.
module fit_policy_hole_allocator #(
    parameter int MAX_HOLES = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_operation,
    input  logic [fpha_pkg::HOLE_IDX_W-1:0]   i_hole_index,
    input  logic [fpha_pkg::REQ_W-1:0]        i_size,
    input  logic                              i_cfg_we,
    input  logic [fpha_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fpha_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_valid,
    output logic                              o_granted,
    output logic [fpha_pkg::HOLE_IDX_W-1:0]   o_chosen_hole
);
    import fpha_pkg::*;

    localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W = $clog2(MAX_HOLES + 1);

    t_state                r_state;
    t_state                n_state;
    logic [1:0]            r_policy;
    logic [COUNT_W-1:0]    r_hole_count;
    logic [CNT_W-1:0]      r_scan;
    logic [CNT_W-1:0]      r_limit;
    logic [CNT_W-1:0]      n_limit;
    logic [SIZE_BITS-1:0]  r_req;
    logic                  r_chk_vld;
    logic [IDX_W-1:0]      r_chk_idx;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic [SIZE_BITS-1:0]  r_mem [MAX_HOLES];
    logic [MAX_HOLES-1:0]  r_used;
    logic                  r_valid;
    logic                  r_granted;
    logic [HOLE_IDX_W-1:0] r_chosen;

    logic                  accept;
    logic                  start_alloc;
    logic                  issue;
    logic                  commit;
    logic                  load_ok;
    logic [IDX_W-1:0]      rd_addr;
    t_fit_ctl              fit_ctl;
    logic                  fit_found;
    logic [IDX_W-1:0]      fit_pick;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign start_alloc = accept && (i_operation == OP_ALLOC);
    assign issue       = r_scan < r_limit;
    assign load_ok     = 32'(i_hole_index) < 32'(MAX_HOLES);
    assign rd_addr     = r_scan[IDX_W-1:0];
    assign n_limit     = (32'(r_hole_count) > 32'(MAX_HOLES)) ? CNT_W'(MAX_HOLES)
                                                              : CNT_W'(r_hole_count);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIRST;
            r_hole_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_POLICY) begin
                r_policy <= i_cfg_data[1:0];
            end else if (i_cfg_idx == REG_HOLE_COUNT) begin
                r_hole_count <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    // Next state and control for the sequencer
    always_comb begin
        n_state        = r_state;
        commit         = 1'b0;
        fit_ctl.clr    = 1'b0;
        fit_ctl.chk    = r_chk_vld;
        fit_ctl.policy = r_policy;
        unique case (r_state)
            ST_IDLE: begin
                if (start_alloc) begin
                    n_state     = ST_SCAN;
                    fit_ctl.clr = 1'b1;
                end
            end
            ST_SCAN: begin
                if (!issue) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and scan pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chk_vld <= 1'b0;
            r_scan    <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == ST_SCAN) && issue;
            if (start_alloc) begin
                r_scan <= '0;
            end else if (r_state == ST_SCAN && issue) begin
                r_scan <= r_scan + 1'b1;
            end
        end
        r_chk_idx <= rd_addr;
        if (start_alloc) begin
            r_limit <= n_limit;
            r_req   <= SIZE_BITS'(i_size);
        end
    end

    // Hole size memory: write on load, read one hole per cycle
    always_ff @(posedge i_clk) begin
        if (accept && i_operation == OP_LOAD && load_ok) begin
            r_mem[IDX_W'(i_hole_index)] <= SIZE_BITS'(i_size);
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Used marks: clear on a clear beat, set on a granted commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (accept && i_operation == OP_CLEAR) begin
            r_used <= '0;
        end else if (commit && fit_found) begin
            r_used[fit_pick] <= 1'b1;
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= commit;
        end
        if (commit) begin
            r_granted <= fit_found;
            r_chosen  <= fit_found ? HOLE_IDX_W'(fit_pick) : '0;
        end
    end

    fpha_fit_unit #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_fit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fit_ctl),
        .i_req       (r_req),
        .i_hole_size (r_rd_data),
        .i_idx       (r_chk_idx),
        .i_used      (r_used[r_chk_idx]),
        .o_found     (fit_found),
        .o_pick      (fit_pick)
    );

    assign o_busy        = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_granted     = r_granted;
    assign o_chosen_hole = r_chosen;

`ifndef SYNTHESIS
    a_valid_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_IDLE) && ($past(r_state) == ST_SCAN))
        else $error("result beat without a finished scan");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_granted |-> o_chosen_hole == '0)
        else $error("nonzero hole reported on a miss");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan <= r_limit))
        else $error("scan pointer ran past the hole limit");
    a_chk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (CNT_W'(r_chk_idx) < r_limit))
        else $error("examined a hole beyond the limit");
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_alloc |=> o_busy)
        else $error("allocate beat did not start a scan");
`endif

endmodule
